>>> sv/spq_pkg.sv
// Shared definitions for the sorted priority queue: command and status codes,
// default capacity and the per-cycle operation struct handed to every cell.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    // Default number of entries held by the queue.
    localparam int unsigned SPQ_CAPACITY = 16;

    // Fixed field widths of the payload.
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned ENTRY_COUNT_W = 5;
    localparam int unsigned CMD_W         = 2;
    localparam int unsigned STATUS_W      = 2;

    // Command codes; the spare code behaves as a query.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2
    } spq_cmd_t;

    // Status codes returned with every result.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_FULL      = 2'd2
    } spq_status_t;

    // Operation broadcast to the whole row of cells in the same cycle.
    typedef struct packed {
        logic insert;
        logic remove;
    } spq_op_t;

endpackage

>>> sv/sorted_priority_queue.sv
// Sorted priority queue: a row of CAPACITY cells kept in priority order.
// The result of an item is registered and presented in the cycle after its transfer.
// Throughput: one item per cycle; every cell acts in parallel on a broadcast
// operation, so the rate is set only by the output register being taken.
// Reset clears the entry count and the output valid; cell contents stay
// undefined until written, and no clearing pass is needed.
`timescale 1ns / 1ps

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY = SPQ_CAPACITY
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [CMD_W-1:0]                 cmd,
    input  logic signed [DATA_W-1:0]         item_value,
    input  logic signed [DATA_W-1:0]         item_priority,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [DATA_W-1:0]         head_value,
    output logic signed [DATA_W-1:0]         head_priority,
    output logic                             is_empty,
    output logic [ENTRY_COUNT_W-1:0]         entry_count,
    output logic [STATUS_W-1:0]              status
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic                     accept;
    spq_op_t                  op;
    logic [STATUS_W-1:0]      status_next;
    logic                     full;
    logic                     empty;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] head_value_reg;
    logic signed [DATA_W-1:0] head_priority_reg;
    logic                     is_empty_reg;
    logic [CNT_W-1:0]         result_count_reg;
    logic [STATUS_W-1:0]      status_reg;

    logic                     cell_stays     [CAPACITY];
    logic signed [DATA_W-1:0] cell_value     [CAPACITY];
    logic signed [DATA_W-1:0] cell_priority  [CAPACITY];
    logic signed [DATA_W-1:0] cell_value_nx  [CAPACITY];
    logic signed [DATA_W-1:0] cell_priority_nx [CAPACITY];

    // A new item is taken whenever the result register is free or being taken.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    // Command decode into the operation broadcast along the chain.
    always_comb
    begin
        op          = '0;
        status_next = ST_OK;
        count_next  = count_reg;
        case (cmd)
            CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    op.insert  = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (empty)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    op.remove  = accept;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                if (empty)
                begin
                    status_next = ST_UNDERFLOW;
                end
            end
        endcase
    end

    // The chain of cells, head at index zero.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                     left_stays;
        logic signed [DATA_W-1:0] left_value;
        logic signed [DATA_W-1:0] left_priority;
        logic signed [DATA_W-1:0] right_value;
        logic signed [DATA_W-1:0] right_priority;

        if (i == 0)
        begin : g_first
            assign left_stays    = 1'b1;
            assign left_value    = item_value;
            assign left_priority = item_priority;
        end
        else
        begin : g_inner
            assign left_stays    = cell_stays[i-1];
            assign left_value    = cell_value[i-1];
            assign left_priority = cell_priority[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value    = cell_value[i];
            assign right_priority = cell_priority[i];
        end
        else
        begin : g_mid
            assign right_value    = cell_value[i+1];
            assign right_priority = cell_priority[i+1];
        end

        spq_cell u_cell (
            .clk            (clk),
            .op             (op),
            .new_value      (item_value),
            .new_priority   (item_priority),
            .head_rule      (i == 0),
            .occupied       (count_reg > CNT_W'(i)),
            .left_stays     (left_stays),
            .left_value     (left_value),
            .left_priority  (left_priority),
            .right_value    (right_value),
            .right_priority (right_priority),
            .stays          (cell_stays[i]),
            .value          (cell_value[i]),
            .prio           (cell_priority[i]),
            .value_next     (cell_value_nx[i]),
            .priority_next  (cell_priority_nx[i])
        );
    end

    // Entry count and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register, loaded with the state after the step.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (count_next == '0)
            begin
                head_value_reg    <= '0;
                head_priority_reg <= '0;
                is_empty_reg      <= 1'b1;
            end
            else
            begin
                head_value_reg    <= cell_value_nx[0];
                head_priority_reg <= cell_priority_nx[0];
                is_empty_reg      <= 1'b0;
            end
            result_count_reg <= count_next;
            status_reg       <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign head_value    = head_value_reg;
    assign head_priority = head_priority_reg;
    assign is_empty      = is_empty_reg;
    assign entry_count   = ENTRY_COUNT_W'(result_count_reg);
    assign status        = status_reg;

    // The reported empty flag agrees with the count carried in the result.
    a_empty_matches_count : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (is_empty_reg == (result_count_reg == '0)))
        else $error("empty flag disagrees with entry count");

    // A dropped insert is only reported when the queue really is full.
    a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FULL) |-> (result_count_reg == CNT_W'(CAPACITY)))
        else $error("full status with spare capacity");

    // A successful remove lowers the count by exactly one.
    a_remove_count : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_REMOVE && !empty) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("remove did not lower the count by one");

    // The two front entries stay in priority order.
    a_front_order : assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_priority[0] >= cell_priority[1]))
        else $error("front entries out of priority order");

endmodule

>>> sv/spq_cell.sv
// One storage cell of the sorted priority queue chain: holds a value and a
// priority and trades them with its neighbours on insert and remove.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic                     clk,
    input  spq_op_t                  op,
    input  logic signed [DATA_W-1:0] new_value,
    input  logic signed [DATA_W-1:0] new_priority,
    input  logic                     head_rule,
    input  logic                     occupied,
    input  logic                     left_stays,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic signed [DATA_W-1:0] left_priority,
    input  logic signed [DATA_W-1:0] right_value,
    input  logic signed [DATA_W-1:0] right_priority,
    output logic                     stays,
    output logic signed [DATA_W-1:0] value,
    output logic signed [DATA_W-1:0] prio,
    output logic signed [DATA_W-1:0] value_next,
    output logic signed [DATA_W-1:0] priority_next
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] priority_reg;

    // The entry stays in place when the new item ranks behind it. The head
    // yields only to a strictly higher priority; other cells also to ties.
    always_comb
    begin
        if (head_rule)
        begin
            stays = occupied && (priority_reg >= new_priority);
        end
        else
        begin
            stays = occupied && (priority_reg > new_priority);
        end
    end

    // Insert: keep, take the new item at the boundary, or shift right by one.
    // Remove: take the right neighbour's entry.
    always_comb
    begin
        value_next    = value_reg;
        priority_next = priority_reg;
        if (op.insert)
        begin
            if (!stays)
            begin
                if (left_stays)
                begin
                    value_next    = new_value;
                    priority_next = new_priority;
                end
                else
                begin
                    value_next    = left_value;
                    priority_next = left_priority;
                end
            end
        end
        else if (op.remove)
        begin
            value_next    = right_value;
            priority_next = right_priority;
        end
    end

    // Entry storage; its contents matter only while the cell is occupied.
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        priority_reg <= priority_next;
    end

    assign value = value_reg;
    assign prio  = priority_reg;

endmodule
